[hw/rtl/vslr_pkg.sv]
// shared constants for the verbatim string literal rewriter
// no dependencies; used by every module of the block but the command queue
`default_nettype none

package vslr_pkg;

    // width of the character fields on the ports
    localparam int CHAR_W          = 16;
    // defaults for the top level parameters
    localparam int CHAR_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    // up to three characters leave for one accepted character
    localparam int MAX_RES         = 3;
    localparam int CNT_W           = 2;

    // characters the scanner reacts to
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_BS    = 8'h5C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

endpackage

`default_nettype wire

[hw/rtl/vslr_front.sv]
// front part: scan state, lookahead hold and rewrite decision per character
// depends on vslr_pkg; emits one packed command per character that yields output
`default_nettype none

module vslr_front #(
    parameter int CW    = 16,
    parameter int CMD_W = 3 * 16 + 3
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept_i,
    input  wire logic [CW-1:0]    char_i,
    input  wire logic             end_i,
    output logic                  push_o,
    output logic [CMD_W-1:0]      cmd_o
);

    typedef enum logic [2:0] {
        MODE_OUT   = 3'd0,
        MODE_SQ    = 3'd1,
        MODE_DQ    = 3'd2,
        MODE_VERB  = 3'd3,
        MODE_LINE  = 3'd4,
        MODE_BLOCK = 3'd5
    } mode_t;

    typedef struct packed {
        logic                             done;
        logic [vslr_pkg::CNT_W-1:0]       cnt;
        logic [vslr_pkg::MAX_RES-1:0][CW-1:0] ch;
    } cmd_t;

    localparam logic [CW-1:0] AT    = CW'(vslr_pkg::CH_AT);
    localparam logic [CW-1:0] SQ    = CW'(vslr_pkg::CH_SQ);
    localparam logic [CW-1:0] DQ    = CW'(vslr_pkg::CH_DQ);
    localparam logic [CW-1:0] BS    = CW'(vslr_pkg::CH_BS);
    localparam logic [CW-1:0] NL    = CW'(vslr_pkg::CH_NL);
    localparam logic [CW-1:0] STAR  = CW'(vslr_pkg::CH_STAR);
    localparam logic [CW-1:0] SLASH = CW'(vslr_pkg::CH_SLASH);

    mode_t         mode_reg, mode_next, mode_d;
    logic [CW-1:0] held_reg, held_next;
    logic          held_v_reg, held_v_next;
    logic [CW-1:0] bh_reg, bh_next;
    logic          bh_v_reg, bh_v_next;

    logic                       prev_ok;
    logic [1:0]                 d_n;
    logic [CW-1:0]              d0, d1;
    logic                       consumed;
    cmd_t                       cmd;

    assign prev_ok = bh_v_reg && (bh_reg != BS);

    // decision on the held character with the new one as lookahead
    always_comb begin
        d_n      = 2'd1;
        d0       = held_reg;
        d1       = held_reg;
        consumed = 1'b0;
        mode_d   = mode_reg;
        priority if (mode_reg == MODE_LINE || mode_reg == MODE_BLOCK) begin
            if (mode_reg == MODE_LINE && held_reg == NL) begin
                mode_d = MODE_OUT;
            end else if (mode_reg == MODE_BLOCK && held_reg == STAR && char_i == SLASH) begin
                mode_d = MODE_OUT;
            end
        end else if (held_reg == AT && char_i == SQ && mode_reg == MODE_OUT) begin
            mode_d   = MODE_VERB;
            d0       = SQ;
            consumed = 1'b1;
        end else if (held_reg == BS && mode_reg == MODE_VERB) begin
            d_n = 2'd2;
            d1  = BS;
        end else if (held_reg == BS && prev_ok &&
                     ((char_i == SQ && mode_reg == MODE_SQ) ||
                      (char_i == DQ && mode_reg == MODE_DQ))) begin
            d_n      = 2'd2;
            d1       = char_i;
            consumed = 1'b1;
        end else if (held_reg == SQ) begin
            if (mode_reg == MODE_OUT) begin
                mode_d = MODE_SQ;
            end else if (mode_reg == MODE_SQ || mode_reg == MODE_VERB) begin
                mode_d = MODE_OUT;
            end
        end else if (held_reg == DQ) begin
            if (mode_reg == MODE_OUT) begin
                mode_d = MODE_DQ;
            end else if (mode_reg == MODE_DQ) begin
                mode_d = MODE_OUT;
            end
        end else if (held_reg == SLASH && char_i == SLASH && mode_reg == MODE_OUT) begin
            mode_d = MODE_LINE;
        end else if (held_reg == SLASH && char_i == STAR && mode_reg == MODE_OUT) begin
            mode_d = MODE_BLOCK;
        end else begin
            mode_d = mode_reg;
        end
    end

    // command assembly and next state
    always_comb begin
        cmd.done  = end_i;
        cmd.ch[0] = char_i;
        cmd.ch[1] = char_i;
        cmd.ch[2] = char_i;
        cmd.cnt   = '0;
        mode_next   = mode_reg;
        held_next   = held_reg;
        held_v_next = held_v_reg;
        bh_next     = bh_reg;
        bh_v_next   = bh_v_reg;
        if (held_v_reg) begin
            cmd.ch[0] = d0;
            cmd.ch[1] = (d_n == 2'd2) ? d1 : char_i;
            cmd.cnt   = d_n + {1'b0, end_i && !consumed};
            mode_next = mode_d;
            bh_v_next = 1'b1;
            if (consumed) begin
                held_v_next = 1'b0;
                bh_next     = char_i;
            end else begin
                held_next = char_i;
                bh_next   = held_reg;
            end
        end else begin
            cmd.cnt = {1'b0, end_i};
            if (!end_i) begin
                held_next   = char_i;
                held_v_next = 1'b1;
            end
        end
        // the end of a text brings everything back to its reset value
        if (end_i) begin
            mode_next   = MODE_OUT;
            held_v_next = 1'b0;
            bh_v_next   = 1'b0;
        end
    end

    assign push_o = accept_i && (cmd.cnt != '0);
    assign cmd_o  = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_OUT;
            held_v_reg <= 1'b0;
            bh_v_reg   <= 1'b0;
        end else if (accept_i) begin
            mode_reg   <= mode_next;
            held_v_reg <= held_v_next;
            bh_v_reg   <= bh_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_i) begin
            held_reg <= held_next;
            bh_reg   <= bh_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vslr_cmd_fifo.sv]
// short command queue between the front and back parts
// depends on nothing beyond its parameters
`default_nettype none

module vslr_cmd_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 51
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_i,
    input  wire logic [WIDTH-1:0] push_data_i,
    input  wire logic             pop_i,
    output logic [WIDTH-1:0]      head_o,
    output logic                  empty_o,
    output logic                  full_o
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]    fill_reg;
    logic             do_push, do_pop;

    assign empty_o = (fill_reg == '0);
    assign full_o  = (fill_reg == NW'(DEPTH));
    assign head_o  = slot_reg[rd_ptr_reg];
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && !empty_o;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data_i;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !full_o)
        else $error("command pushed into a full queue");

    a_fill_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        !(full_o && empty_o))
        else $error("queue reports full and empty at once");

endmodule

`default_nettype wire

[hw/rtl/vslr_back.sv]
// back part: walks the characters of the head command out on the result stream
// depends on vslr_pkg; reads the command queue head
`default_nettype none

module vslr_back #(
    parameter int CW    = 16,
    parameter int CMD_W = 3 * 16 + 3
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [CMD_W-1:0]            head_i,
    input  wire logic                        empty_i,
    output logic                             pop_o,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [vslr_pkg::CHAR_W-1:0]      m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser
);

    localparam int DW = vslr_pkg::CHAR_W;

    typedef struct packed {
        logic                             done;
        logic [vslr_pkg::CNT_W-1:0]       cnt;
        logic [vslr_pkg::MAX_RES-1:0][CW-1:0] ch;
    } cmd_t;

    cmd_t                       head;
    logic [vslr_pkg::CNT_W-1:0] sel_reg;
    logic                       last_of_cmd;
    logic                       xfer;

    assign head        = head_i;
    assign last_of_cmd = (sel_reg == head.cnt - 1'b1);
    assign xfer        = m_tvalid && m_tready;

    assign m_tvalid = !empty_i;
    assign m_tdata  = DW'(head.ch[sel_reg]);
    assign m_tlast  = last_of_cmd;
    assign m_tuser  = last_of_cmd && head.done;
    assign pop_o    = xfer && last_of_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= '0;
        end else if (xfer) begin
            sel_reg <= last_of_cmd ? '0 : sel_reg + 1'b1;
        end
    end

    a_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty_i |-> (head.cnt != '0) && (sel_reg < head.cnt))
        else $error("head command has no character at the current index");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of text flagged before the last character of its command");

endmodule

`default_nettype wire

[hw/rtl/verbatim_string_literal_rewriter_core.sv]
// top level of the verbatim string literal rewriter
// depends on vslr_pkg, vslr_front, vslr_cmd_fifo and vslr_back
`default_nettype none

// channel   dir  ports                          contents
// s_ (in)   in   s_tvalid s_tready s_tdata s_tlast  one source character, tlast = last of text
// m_ (out)  out  m_tvalid m_tready m_tdata m_tlast m_tuser  one rewritten character
//
// one source character is taken per cycle while the command queue has room
// each character turns into zero to three output characters, sent one per cycle while m_tready is high
// the queue between scanner and output absorbs bursts; s_tready drops only when it is full
// the command for a held character is formed when its lookahead character is accepted and goes through the queue
// aresetn is synchronous and active low; it returns the scanner to its start state

module verbatim_string_literal_rewriter_core #(
    parameter int CHAR_BITS   = vslr_pkg::CHAR_BITS_DEF,
    parameter int QUEUE_DEPTH = vslr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // source stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [vslr_pkg::CHAR_W-1:0] s_tdata,   // [15:0] char_in
    input  wire logic                        s_tlast,   // text_end
    // rewritten stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [vslr_pkg::CHAR_W-1:0]      m_tdata,   // [15:0] char_out
    output logic                             m_tlast,   // run_last
    output logic                             m_tuser    // [0] text_done
);

    // characters are kept only as wide as the character set needs
    localparam int CW    = (CHAR_BITS < vslr_pkg::CHAR_W) ? CHAR_BITS : vslr_pkg::CHAR_W;
    // command: done flag, character count, three character slots
    localparam int CMD_W = vslr_pkg::MAX_RES * CW + vslr_pkg::CNT_W + 1;

    logic             accept;
    logic             push;
    logic [CMD_W-1:0] cmd;
    logic [CMD_W-1:0] head;
    logic             empty, full;
    logic             pop;

    // a transfer on the source side happens whenever s_tvalid is high and the queue has room
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // scanner: mode tracking and the one character lookahead
    vslr_front #(
        .CW    (CW),
        .CMD_W (CMD_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept_i (accept),
        .char_i   (s_tdata[CW-1:0]),
        .end_i    (s_tlast),
        .push_o   (push),
        .cmd_o    (cmd)
    );

    // decouples the scanner from output stalls
    vslr_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (CMD_W)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (push),
        .push_data_i (cmd),
        .pop_i       (pop),
        .head_o      (head),
        .empty_o     (empty),
        .full_o      (full)
    );

    // serializer: one output transfer per character of a command
    vslr_back #(
        .CW    (CW),
        .CMD_W (CMD_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_i   (head),
        .empty_i  (empty),
        .pop_o    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

[tb/tb_verbatim_string_literal_rewriter_core.sv]
// testbench for verbatim_string_literal_rewriter_core: random and directed script texts
// depends on vslr_pkg and the core; a built-in scanner predicts every rewritten character
`timescale 1ns / 100ps

module tb_verbatim_string_literal_rewriter_core;

    // run ends here even if the core hangs
    localparam int CYCLE_LIMIT = 200000;
    // random characters to send after the directed texts
    localparam int RANDOM_CHARS = 340;
    // sink and source stay busy while the count of sent transfers lies in this range
    localparam int CALM_FROM = 150;
    localparam int CALM_TO   = 260;

    // characters the scanner reacts to, widened to the port width
    localparam logic [vslr_pkg::CHAR_W-1:0] K_AT    = {8'h00, vslr_pkg::CH_AT};
    localparam logic [vslr_pkg::CHAR_W-1:0] K_SQ    = {8'h00, vslr_pkg::CH_SQ};
    localparam logic [vslr_pkg::CHAR_W-1:0] K_DQ    = {8'h00, vslr_pkg::CH_DQ};
    localparam logic [vslr_pkg::CHAR_W-1:0] K_BS    = {8'h00, vslr_pkg::CH_BS};
    localparam logic [vslr_pkg::CHAR_W-1:0] K_NL    = {8'h00, vslr_pkg::CH_NL};
    localparam logic [vslr_pkg::CHAR_W-1:0] K_STAR  = {8'h00, vslr_pkg::CH_STAR};
    localparam logic [vslr_pkg::CHAR_W-1:0] K_SLASH = {8'h00, vslr_pkg::CH_SLASH};

    // where the scanner stands in the text
    typedef enum logic [2:0] {
        SCAN_OUT,
        SCAN_SQ,
        SCAN_DQ,
        SCAN_VERB,
        SCAN_LINE,
        SCAN_BLOCK
    } scan_mode_t;

    typedef struct packed {
        logic [vslr_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } src_char_t;

    typedef struct packed {
        logic [vslr_pkg::CHAR_W-1:0] ch;
        logic                        run_last;
        logic                        text_done;
    } out_char_t;

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [vslr_pkg::CHAR_W-1:0] s_tdata  = '0;
    logic                        s_tlast  = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [vslr_pkg::CHAR_W-1:0] m_tdata;
    logic                        m_tlast;
    logic                        m_tuser;

    // characters waiting to be sent, and what the core owes us
    src_char_t                   src_q[$];
    out_char_t                   rewritten_q[$];
    out_char_t                   step_q[$];
    logic [vslr_pkg::CHAR_W-1:0] text_buf[$];

    int sent_cnt  = 0;
    int acc_cnt   = 0;
    int err_cnt   = 0;
    int cycle_cnt = 0;

    // scanner state of the prediction
    scan_mode_t                  mode;
    logic [vslr_pkg::CHAR_W-1:0] held_ch;
    bit                          held_ok;
    logic [vslr_pkg::CHAR_W-1:0] prev_ch;
    bit                          prev_ok;

    // a stretch in the middle of the run with no idling on either side
    wire calm_stretch = (sent_cnt >= CALM_FROM) && (sent_cnt < CALM_TO);

    verbatim_string_literal_rewriter_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic void push_out(input logic [vslr_pkg::CHAR_W-1:0] ch);
        out_char_t o;
        o.ch        = ch;
        o.run_last  = 1'b0;
        o.text_done = 1'b0;
        step_q.push_back(o);
    endfunction

    function automatic void clear_scan();
        mode    = SCAN_OUT;
        held_ch = '0;
        held_ok = 1'b0;
        prev_ch = '0;
        prev_ok = 1'b0;
    endfunction

    // rewrite held character h seeing lookahead c; returns 1 when c is used up too
    function automatic bit scan_lookahead(input logic [vslr_pkg::CHAR_W-1:0] h,
                                          input logic [vslr_pkg::CHAR_W-1:0] c);
        // a backslash only escapes when the one before it is no backslash
        // and belongs to this text
        bit esc_ok = prev_ok && (prev_ch != K_BS);
        // inside comments everything goes through, only the closer matters
        if (mode == SCAN_LINE || mode == SCAN_BLOCK) begin
            if (mode == SCAN_LINE && h == K_NL)
                mode = SCAN_OUT;
            else if (mode == SCAN_BLOCK && h == K_STAR && c == K_SLASH)
                mode = SCAN_OUT;
            push_out(h);
            return 1'b0;
        end
        // @' opens a verbatim literal and is written as a plain quote
        if (h == K_AT && c == K_SQ && mode == SCAN_OUT) begin
            mode = SCAN_VERB;
            push_out(K_SQ);
            return 1'b1;
        end
        // backslashes double inside verbatim literals
        if (h == K_BS && mode == SCAN_VERB) begin
            push_out(K_BS);
            push_out(K_BS);
            return 1'b0;
        end
        // escaped quote inside an ordinary string leaves the string open
        if (h == K_BS && esc_ok &&
            ((c == K_SQ && mode == SCAN_SQ) || (c == K_DQ && mode == SCAN_DQ))) begin
            push_out(h);
            push_out(c);
            return 1'b1;
        end
        if (h == K_SQ) begin
            if (mode == SCAN_OUT)
                mode = SCAN_SQ;
            else if (mode == SCAN_SQ || mode == SCAN_VERB)
                mode = SCAN_OUT;
            push_out(h);
            return 1'b0;
        end
        if (h == K_DQ) begin
            if (mode == SCAN_OUT)
                mode = SCAN_DQ;
            else if (mode == SCAN_DQ)
                mode = SCAN_OUT;
            push_out(h);
            return 1'b0;
        end
        // comment openers
        if (h == K_SLASH && c == K_SLASH && mode == SCAN_OUT)
            mode = SCAN_LINE;
        else if (h == K_SLASH && c == K_STAR && mode == SCAN_OUT)
            mode = SCAN_BLOCK;
        push_out(h);
        return 1'b0;
    endfunction

    // one accepted source character -> zero to three rewritten characters
    function automatic void rewrite_char(input logic [vslr_pkg::CHAR_W-1:0] c,
                                         input logic last);
        logic [vslr_pkg::CHAR_W-1:0] h;
        bit used = 1'b0;
        step_q.delete();
        if (held_ok) begin
            h    = held_ch;
            used = scan_lookahead(h, c);
            if (used) begin
                // pair used up: nothing held, next character waits for its own lookahead
                held_ok = 1'b0;
                held_ch = '0;
                prev_ch = c;
            end else begin
                held_ch = c;
                prev_ch = h;
            end
            prev_ok = 1'b1;
        end else if (!last) begin
            held_ch = c;
            held_ok = 1'b1;
        end
        if (last) begin
            // last character goes through as it is, unless a pair already took it
            if (!used)
                push_out(c);
            step_q[step_q.size()-1].text_done = 1'b1;
            clear_scan();
        end
        if (step_q.size() != 0)
            step_q[step_q.size()-1].run_last = 1'b1;
        foreach (step_q[i])
            rewritten_q.push_back(step_q[i]);
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    function automatic void queue_text(input string s);
        src_char_t it;
        for (int i = 0; i < s.len(); i++) begin
            it.ch   = {8'h00, s[i]};
            it.last = (i == s.len() - 1);
            src_q.push_back(it);
        end
    endfunction

    function automatic void queue_char(input logic [vslr_pkg::CHAR_W-1:0] ch, input logic last);
        src_char_t it;
        it.ch   = ch;
        it.last = last;
        src_q.push_back(it);
    endfunction

    // characters weighted toward the ones the scanner cares about
    function automatic logic [vslr_pkg::CHAR_W-1:0] pick_char();
        int unsigned r = $urandom_range(99);
        if (r < 10)      return K_AT;
        else if (r < 20) return K_SQ;
        else if (r < 27) return K_DQ;
        else if (r < 38) return K_BS;
        else if (r < 42) return K_NL;
        else if (r < 47) return K_STAR;
        else if (r < 53) return K_SLASH;
        else if (r < 63) return vslr_pkg::CHAR_W'($urandom);
        // special low byte under a nonzero high byte must not match
        else if (r < 68) return {8'($urandom_range(1, 255)), vslr_pkg::CH_SQ};
        else             return vslr_pkg::CHAR_W'(16'h0061 + $urandom_range(25));
    endfunction

    // append one well-formed construct with random content, or plain noise
    function automatic void add_fragment();
        int unsigned kind = $urandom_range(9);
        int unsigned len  = $urandom_range(0, 4);
        case (kind)
            0, 1: begin
                text_buf.push_back(K_AT);
                text_buf.push_back(K_SQ);
                repeat (len) text_buf.push_back(pick_char());
                text_buf.push_back(K_SQ);
            end
            2: begin
                text_buf.push_back(K_SQ);
                repeat (len) text_buf.push_back(pick_char());
                if ($urandom_range(1) != 0) begin
                    text_buf.push_back(K_BS);
                    text_buf.push_back(K_SQ);
                end
                text_buf.push_back(K_SQ);
            end
            3: begin
                text_buf.push_back(K_DQ);
                repeat (len) text_buf.push_back(pick_char());
                if ($urandom_range(1) != 0) begin
                    text_buf.push_back(K_BS);
                    text_buf.push_back(K_DQ);
                end
                text_buf.push_back(K_DQ);
            end
            4: begin
                text_buf.push_back(K_SLASH);
                text_buf.push_back(K_SLASH);
                repeat (len) text_buf.push_back(pick_char());
                text_buf.push_back(K_NL);
            end
            5: begin
                text_buf.push_back(K_SLASH);
                text_buf.push_back(K_STAR);
                repeat (len) text_buf.push_back(pick_char());
                text_buf.push_back(K_STAR);
                text_buf.push_back(K_SLASH);
            end
            default: begin
                repeat (len + 1) text_buf.push_back(pick_char());
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // source driver: next transfer offered at the falling edge once the
    // current one is taken
    // ---------------------------------------------------------------

    always @(negedge aclk) begin : src_drive
        src_char_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (acc_cnt == sent_cnt) begin
            if (src_q.size() != 0 && (calm_stretch || $urandom_range(99) >= 7)) begin
                it = src_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.ch;
                s_tlast  <= it.last;
                sent_cnt++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink stalls at random, also while reset is held
    always @(negedge aclk) begin
        m_tready <= calm_stretch || ($urandom_range(99) >= 7);
    end

    // ---------------------------------------------------------------
    // monitor: predict on each source transfer, then check each result
    // transfer against the oldest expected character
    // ---------------------------------------------------------------

    always @(posedge aclk) begin : watch
        out_char_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                rewrite_char(s_tdata, s_tlast);
                acc_cnt++;
            end
            if (m_tvalid && m_tready) begin
                if (rewritten_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %h", m_tdata));
                end else begin
                    want = rewritten_q.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch($sformatf("char_out %h, want %h", m_tdata, want.ch));
                    if (m_tlast !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b (char %h)",
                                                  m_tlast, want.run_last, want.ch));
                    if (m_tuser !== want.text_done)
                        report_mismatch($sformatf("text_done %b, want %b (char %h)",
                                                  m_tuser, want.text_done, want.ch));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_verbatim_string_literal_rewriter_core failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin : main_seq
        int rand_chars;
        int nfrag;
        int cut;
        clear_scan();

        // directed texts
        queue_text("@");                   // one character: nothing held, goes straight out
        queue_char(16'h0000, 1'b0);        // field extremes
        queue_char(16'hFFFF, 1'b1);
        queue_text("@'\\'");               // verbatim with a doubled backslash, then closed
        queue_text("'\\'@'");              // escaped quote keeps the string open, @ ignored
        queue_text("\"\\\"");              // escaped double quote ending on the last char
        queue_text("@'");                  // verbatim opener ending on the last char
        queue_text("\\'");                 // backslash as first character of a text
        queue_text("//@\n/*@*/");          // @ inside line and block comments

        // random texts built from constructs, some cut short
        rand_chars = 0;
        while (rand_chars < RANDOM_CHARS) begin
            text_buf.delete();
            nfrag = $urandom_range(1, 4);
            repeat (nfrag) add_fragment();
            if ($urandom_range(7) == 0) begin
                cut = $urandom_range(1, text_buf.size());
                while (text_buf.size() > cut) void'(text_buf.pop_back());
            end
            foreach (text_buf[i])
                queue_char(text_buf[i], i == text_buf.size() - 1);
            rand_chars += text_buf.size();
        end

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // every source transfer taken
        while (src_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        // every expected character back
        while (rewritten_q.size() != 0)
            @(posedge aclk);
        // room for stray extra characters to show up
        repeat (24) @(posedge aclk);

        if (rewritten_q.size() != 0)
            report_mismatch($sformatf("%0d chars never arrived", rewritten_q.size()));
        if (err_cnt == 0) begin
            $display("tb_verbatim_string_literal_rewriter_core passed");
        end else begin
            $display("tb_verbatim_string_literal_rewriter_core failed");
        end
        $finish;
    end

endmodule
